@@ rtl/bins_pkg.sv @@
// ----------------------------------------------------------------------------
// bins_pkg
// Shared types, register indexes, field widths and reset values of the
// one-bit-per-pixel nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package bins_pkg;

	localparam int DEF_IMAGE_BYTES = 8192;
	localparam int DEF_MAX_DIM     = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_DIM_W  = 9;
	localparam int COLOR_W    = 16;
	localparam int ADDR_IN_W  = 13;
	localparam int BYTE_W     = 8;
	localparam int BIT_SEL_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR  = 3'd5;

	localparam logic [CFG_DIM_W-1:0] RST_DEST_WIDTH  = 9'd128;
	localparam logic [CFG_DIM_W-1:0] RST_DEST_HEIGHT = 9'd160;
	localparam logic [CFG_DIM_W-1:0] RST_SRC_WIDTH   = 9'd128;
	localparam logic [CFG_DIM_W-1:0] RST_SRC_HEIGHT  = 9'd160;
	localparam logic [COLOR_W-1:0]   RST_FORE_COLOR  = 16'hFFFF;
	localparam logic [COLOR_W-1:0]   RST_BACK_COLOR  = 16'h0000;

	// input actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EMIT  = 1'b1;

	// leftmost pixel sits in the top bit of a byte
	localparam logic [BIT_SEL_W-1:0] MSB_BIT  = 3'd7;
	localparam logic [BIT_SEL_W-1:0] BIT_MASK = 3'h7;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] dest_width;
		logic [CFG_DIM_W-1:0] dest_height;
		logic [CFG_DIM_W-1:0] src_width;
		logic [CFG_DIM_W-1:0] src_height;
		logic [COLOR_W-1:0]   fore_color;
		logic [COLOR_W-1:0]   back_color;
	} bins_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bins_div_stat_t;

endpackage

@@ rtl/binary_image_nearest_scaler_unit.sv @@
// Emit: column multiply, bit-serial column divide, store read and output when the
// source row base is cached; the first pixel of a row first adds a row multiply,
// a row divide and a base set. NW is the divider width (16 at default sizes).
// One item at a time. Byte write: direct when the store depth is a power of two;
// other depths add a modulo state to emits, and to writes below 2^ADDR_IN_W bytes.
// Reset: counters zero, registers to defaults; the image store is not cleared.
// ----------------------------------------------------------------------------
// binary_image_nearest_scaler_unit
// Nearest-neighbour scaler over a packed one-bit image held in a byte RAM;
// each emit yields the next output pixel in raster order.
// ----------------------------------------------------------------------------
module binary_image_nearest_scaler_unit
	import bins_pkg::*;
#(
	parameter int IMAGE_BYTES = DEF_IMAGE_BYTES,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  action,
	input  logic [ADDR_IN_W-1:0]  write_address,
	input  logic [BYTE_W-1:0]     write_byte,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW   = $clog2(MAX_DIM);
	localparam int DIMW = $clog2(MAX_DIM + 1);
	localparam int SRW  = $clog2(MAX_DIM * MAX_DIM);
	localparam int PIXW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
	localparam int BIW  = PIXW - BIT_SEL_W;
	localparam int PRW  = SRW + DIMW;
	localparam int AW   = $clog2(IMAGE_BYTES);
	localparam int NW   = SRW;
	localparam int MXW  = (BIW > ADDR_IN_W) ? BIW : ADDR_IN_W;
	localparam int RSH  = MXW + AW;
	localparam int MW   = MXW + 2;
	localparam int MPW  = MXW + MW;
	localparam logic [MW-1:0]  RECIP   = MW'(((64'd1 << RSH) + 64'(IMAGE_BYTES) - 64'd1)
		/ 64'(IMAGE_BYTES));
	localparam logic [MXW-1:0] STORE_N = MXW'(IMAGE_BYTES);
	localparam bit POW2   = (IMAGE_BYTES & (IMAGE_BYTES - 1)) == 0;
	localparam bit RD_MOD = !POW2 && ((1 << BIW) > IMAGE_BYTES);
	localparam bit WR_MOD = !POW2 && (IMAGE_BYTES < (1 << ADDR_IN_W));

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_WR_DIV   = 11'b000_0000_0010,
		S_ROW_MUL  = 11'b000_0000_0100,
		S_ROW_DIV  = 11'b000_0000_1000,
		S_BASE_MUL = 11'b000_0001_0000,
		S_BASE_SET = 11'b000_0010_0000,
		S_COL_MUL  = 11'b000_0100_0000,
		S_COL_DIV  = 11'b000_1000_0000,
		S_RD_DIV   = 11'b001_0000_0000,
		S_RD       = 11'b010_0000_0000,
		S_OUT      = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	bins_cfg_t           cfg;
	bins_div_stat_t      div_stat;
	logic                cfg_wr;
	logic                item_fire;
	logic                out_fire;
	logic [DIMW-1:0]     dw;
	logic [DIMW-1:0]     dh;
	logic [DIMW-1:0]     sw;
	logic [DIMW-1:0]     sh;
	logic [CW-1:0]       col_q;
	logic [CW-1:0]       row_q;
	logic                row_ok_q;
	logic [PIXW-1:0]     row_base_q;
	logic [SRW-1:0]      srow_q;
	logic [PRW-1:0]      prod_q;
	logic [PIXW-1:0]     pix_q;
	logic [BYTE_W-1:0]   wr_byte_q;
	logic                out_valid_q;
	logic [COLOR_W-1:0]  pixel_color_q;
	logic                frame_last_q;
	logic [SRW-1:0]      mul_a;
	logic [DIMW-1:0]     mul_b;
	logic [PRW-1:0]      mul_p;
	logic                div_start;
	logic [NW-1:0]       div_dividend;
	logic [DIMW-1:0]     div_divisor;
	logic [NW-1:0]       div_quo;
	logic [PIXW-1:0]     pix_sum;
	logic [MXW-1:0]      mod_x;
	logic [MPW-1:0]      mod_prod;
	logic [MXW-1:0]      mod_x_q;
	logic [MXW-1:0]      mod_quo_q;
	logic [2*MXW-1:0]    mod_back;
	logic [MXW-1:0]      mod_rem;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [BYTE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;
	logic [BIT_SEL_W-1:0] bit_sel;
	logic                pix_bit;
	logic [CW:0]         col_inc;
	logic [CW:0]         row_inc;
	logic                col_wrap;
	logic                row_wrap;

	function automatic logic [DIMW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
		if (v == '0) begin
			return DIMW'(1);
		end
		if (32'(v) > MAX_DIM) begin
			return DIMW'(MAX_DIM);
		end
		return DIMW'(v);
	endfunction

	bins_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_wr),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bins_div #(
		.NW (NW),
		.DW (DIMW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.stat      (div_stat)
	);

	bins_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (IMAGE_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign item_stall = (state_q != S_IDLE);
	assign item_fire  = item_valid && !item_stall;
	assign out_fire   = (state_q == S_OUT) && (!out_valid_q || !result_stall);

	always_comb begin
		dw = clamp_dim(cfg.dest_width);
		dh = clamp_dim(cfg.dest_height);
		sw = clamp_dim(cfg.src_width);
		sh = clamp_dim(cfg.src_height);
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			S_ROW_MUL: begin
				mul_a = SRW'(row_q);
				mul_b = sh;
			end
			S_BASE_MUL: begin
				mul_a = srow_q;
				mul_b = sw;
			end
			default: begin
				mul_a = SRW'(col_q);
				mul_b = sw;
			end
		endcase
		mul_p = PRW'(mul_a) * PRW'(mul_b);
	end

	assign pix_sum = row_base_q + PIXW'(div_quo[SRW-1:0]);

	// byte index modulo the store depth by reciprocal multiplication
	always_comb begin
		mod_x    = (state_q == S_RD_DIV) ? MXW'(pix_q[PIXW-1:BIT_SEL_W])
			: MXW'(write_address);
		mod_prod = MPW'(mod_x) * MPW'(RECIP);
		mod_back = (2 * MXW)'(mod_quo_q) * (2 * MXW)'(STORE_N);
		mod_rem  = mod_x_q - mod_back[MXW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					if (action == ACT_WRITE) begin
						state_d = WR_MOD ? S_WR_DIV : S_IDLE;
					end else begin
						state_d = row_ok_q ? S_COL_MUL : S_ROW_MUL;
					end
				end
			end
			S_WR_DIV: begin
				state_d = S_IDLE;
			end
			S_ROW_MUL: begin
				state_d = S_ROW_DIV;
			end
			S_ROW_DIV: begin
				if (div_stat.done) begin
					state_d = S_BASE_MUL;
				end
			end
			S_BASE_MUL: begin
				state_d = S_BASE_SET;
			end
			S_BASE_SET: begin
				state_d = S_COL_MUL;
			end
			S_COL_MUL: begin
				state_d = S_COL_DIV;
			end
			S_COL_DIV: begin
				if (div_stat.done) begin
					state_d = RD_MOD ? S_RD_DIV : S_RD;
				end
			end
			S_RD_DIV: begin
				state_d = S_RD;
			end
			S_RD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// divider start on entry to a divide state
	always_comb begin
		div_dividend = '0;
		div_divisor  = '0;
		case (state_d)
			S_ROW_DIV: begin
				div_dividend = NW'(mul_p[SRW-1:0]);
				div_divisor  = dh;
			end
			S_COL_DIV: begin
				div_dividend = NW'(mul_p[SRW-1:0]);
				div_divisor  = dw;
			end
			default: begin
			end
		endcase
		div_start = (state_d != state_q)
			&& (state_d == S_ROW_DIV || state_d == S_COL_DIV);
	end

	// image store ports
	always_comb begin
		if (WR_MOD) begin
			ram_we    = (state_q == S_WR_DIV);
			ram_waddr = AW'(mod_rem);
			ram_wdata = wr_byte_q;
		end else begin
			ram_we    = item_fire && (action == ACT_WRITE);
			ram_waddr = AW'(write_address);
			ram_wdata = write_byte;
		end
		ram_re = (state_q == S_RD);
		if (RD_MOD) begin
			ram_raddr = AW'(mod_rem);
		end else begin
			ram_raddr = AW'(pix_q[PIXW-1:BIT_SEL_W]);
		end
	end

	always_comb begin
		bit_sel  = MSB_BIT - (pix_q[BIT_SEL_W-1:0] & BIT_MASK);
		pix_bit  = ram_rdata[bit_sel];
		col_inc  = {1'b0, col_q} + 1'b1;
		row_inc  = {1'b0, row_q} + 1'b1;
		col_wrap = col_inc >= (CW + 1)'(dw);
		row_wrap = row_inc >= (CW + 1)'(dh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			row_ok_q    <= 1'b0;
			row_base_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				row_ok_q <= 1'b0;
			end else if (state_q == S_BASE_SET) begin
				row_ok_q   <= 1'b1;
				row_base_q <= prod_q[PIXW-1:0];
			end else if (out_fire && col_wrap) begin
				row_ok_q <= 1'b0;
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[CW-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROW_MUL || state_q == S_BASE_MUL || state_q == S_COL_MUL) begin
			prod_q <= mul_p;
		end
		if (state_q == S_ROW_DIV && div_stat.done) begin
			srow_q <= div_quo[SRW-1:0];
		end
		if (state_q == S_COL_DIV && div_stat.done) begin
			pix_q <= pix_sum;
		end
		if (item_fire) begin
			wr_byte_q <= write_byte;
		end
		if ((item_fire && action == ACT_WRITE) || state_q == S_RD_DIV) begin
			mod_x_q   <= mod_x;
			mod_quo_q <= MXW'(mod_prod >> RSH);
		end
		if (out_fire) begin
			pixel_color_q <= pix_bit ? cfg.fore_color : cfg.back_color;
			frame_last_q  <= col_wrap && row_wrap;
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_color  = pixel_color_q;
	assign frame_last   = frame_last_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_ROW_DIV || state_q == S_COL_DIV))
		else $error("divide finished outside a divide state");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_last_q) |-> (col_q == '0 && row_q == '0))
		else $error("frame end shown but counters not at frame start");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> ({1'b0, col_q} < (CW + 1)'(dw)))
		else $error("column counter past raster width after advance");

endmodule

@@ rtl/bins_ram.sv @@
// ----------------------------------------------------------------------------
// bins_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bins_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bins_div.sv @@
// ----------------------------------------------------------------------------
// bins_div
// Restoring divider, one quotient bit per cycle. The quotient is valid in the
// cycle that done is high and holds until the next start.
// ----------------------------------------------------------------------------
module bins_div
	import bins_pkg::*;
#(
	parameter int NW = ADDR_IN_W,
	parameter int DW = CFG_DIM_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [NW-1:0]  dividend,
	input  logic [DW-1:0]  divisor,
	output logic [NW-1:0]  quotient,
	output bins_div_stat_t stat
);

	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  div_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW:0]    shifted;
	logic [DW:0]    diff;
	logic           ge;

	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign quotient   = quo_q;
	assign stat.busy  = busy_q;
	assign stat.done  = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

endmodule

@@ rtl/bins_cfg.sv @@
// ----------------------------------------------------------------------------
// bins_cfg
// Configuration register file: raster sizes and the two output colors.
// ----------------------------------------------------------------------------
module bins_cfg
	import bins_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output bins_cfg_t             cfg
);

	bins_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_width  <= RST_DEST_WIDTH;
			cfg_q.dest_height <= RST_DEST_HEIGHT;
			cfg_q.src_width   <= RST_SRC_WIDTH;
			cfg_q.src_height  <= RST_SRC_HEIGHT;
			cfg_q.fore_color  <= RST_FORE_COLOR;
			cfg_q.back_color  <= RST_BACK_COLOR;
		end else if (wr) begin
			case (index)
				CFG_DEST_WIDTH: begin
					cfg_q.dest_width <= data[CFG_DIM_W-1:0];
				end
				CFG_DEST_HEIGHT: begin
					cfg_q.dest_height <= data[CFG_DIM_W-1:0];
				end
				CFG_SRC_WIDTH: begin
					cfg_q.src_width <= data[CFG_DIM_W-1:0];
				end
				CFG_SRC_HEIGHT: begin
					cfg_q.src_height <= data[CFG_DIM_W-1:0];
				end
				CFG_FORE_COLOR: begin
					cfg_q.fore_color <= data[COLOR_W-1:0];
				end
				CFG_BACK_COLOR: begin
					cfg_q.back_color <= data[COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
